[rtl/pre_pkg.sv]
`default_nettype none
package pre_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned MAG_W   = 33;
  localparam int unsigned PROD_W  = 66;
  localparam int unsigned SUM_W   = 68;
  localparam int unsigned ROOT_W  = 34;
  localparam int unsigned REM_W   = 37;
  localparam int unsigned QUOT_W  = 15;
  localparam int unsigned NUM_W   = 47;
  localparam int unsigned DREM_W  = 34;
  localparam int unsigned DIR_W   = 16;
  localparam int unsigned ARC_W   = 48;
  localparam int unsigned MIN_W   = 16;
  localparam int unsigned AXES    = 3;

  localparam logic [2:0] VTX_LAST     = 3'd5;
  localparam logic [5:0] SQ_LAST      = 6'd3;
  localparam logic [5:0] ROOT_FIRST   = 6'd33;
  localparam logic [5:0] DIV_FIRST    = 6'd14;
  localparam logic [ARC_W-1:0] ARC_MAX = '1;

  typedef struct packed {
    logic               first;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [COORD_W-1:0] pz;
    logic [COORD_W-1:0] qx;
    logic [COORD_W-1:0] qy;
    logic [COORD_W-1:0] qz;
  } qent_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_CHECK,
    ST_DIVIDE,
    ST_EMIT
  } back_state_t;

  // Corner order over the six vertices is 0,1,2,1,3,2.
  function automatic logic [1:0] corner_of(input logic [2:0] k);
    logic [1:0] c;
    unique case (k)
      3'd0:    c = 2'd0;
      3'd1:    c = 2'd1;
      3'd2:    c = 2'd2;
      3'd3:    c = 2'd1;
      3'd4:    c = 2'd3;
      default: c = 2'd2;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

[rtl/pre_point_if.sv]
`default_nettype none
interface pre_point_if;
  logic        valid;
  logic        ready;
  logic [31:0] point_x;
  logic [31:0] point_y;
  logic [31:0] point_z;
  logic        first_point;

  modport source(output valid, point_x, point_y, point_z, first_point, input ready);
  modport sink(input valid, point_x, point_y, point_z, first_point, output ready);
endinterface
`default_nettype wire

[rtl/pre_vertex_if.sv]
`default_nettype none
interface pre_vertex_if;
  logic        valid;
  logic        ready;
  logic [31:0] vert_x;
  logic [31:0] vert_y;
  logic [31:0] vert_z;
  logic [15:0] dir_x;
  logic [15:0] dir_y;
  logic [15:0] dir_z;
  logic [47:0] arc_length;
  logic        side;
  logic        last_vertex;

  modport source(output valid, vert_x, vert_y, vert_z, dir_x, dir_y, dir_z, arc_length,
                 side, last_vertex, input ready);
  modport sink(input valid, vert_x, vert_y, vert_z, dir_x, dir_y, dir_z, arc_length,
               side, last_vertex, output ready);
endinterface
`default_nettype wire

[rtl/polyline_ribbon_expander.sv]
// Polyline ribbon expander.
// Points of a 3D polyline enter on the points channel (valid/ready, an item
// is taken when both are high). A point marked first, or any point while no
// point is stored, starts a line: it is stored, the arc is cleared and no
// vertex leaves. Each later point forms a segment with the stored point; the
// block emits six ribbon vertices for it on the vertices channel, or none if
// the segment is shorter than min_segment_length or of zero length.
// The front stores the previous point and queues items in a two-entry queue,
// so it keeps taking points while the back is busy. The back squares the
// differences, takes a bit-serial square root, checks the length, runs three
// shift-subtract dividers in parallel and then emits six vertices, one a
// cycle while the receiver takes them. A stalled receiver holds the output
// register and the back waits.
// Reset (synchronous, active high) empties the queue, forgets the stored
// point, clears the arc and sets the minimum length to MIN_RESET (default 1).
// The minimum length register is written through cfg_write and cfg_data.
`default_nettype none
module polyline_ribbon_expander #(
  parameter int unsigned MIN_RESET = 1
) (
  input  wire logic        clk,
  input  wire logic        rst,
  pre_point_if.sink        points,
  pre_vertex_if.source     vertices,
  input  wire logic        cfg_write,
  input  wire logic [15:0] cfg_data
);
  import pre_pkg::*;

  logic             push;
  logic             pop;
  logic             full;
  logic             empty;
  qent_t            wr_entry;
  qent_t            rd_entry;
  logic [MIN_W-1:0] min_segment_length;

  // The register holds its reset value until the first write.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_segment_length <= MIN_W'(MIN_RESET);
    end else if (cfg_write) begin
      min_segment_length <= cfg_data;
    end
  end

  // The front part classifies each item and remembers the previous point.
  pre_front u_front (
    .clk   (clk),
    .rst   (rst),
    .points(points),
    .full  (full),
    .push  (push),
    .entry (wr_entry)
  );

  // The queue lets the front go on while the back works on a segment.
  pre_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_entry(wr_entry),
    .pop     (pop),
    .rd_entry(rd_entry),
    .full    (full),
    .empty   (empty)
  );

  // The back part computes length, tangent and arc and emits the vertices.
  pre_back u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (empty),
    .head   (rd_entry),
    .pop    (pop),
    .min_len(min_segment_length),
    .verts  (vertices)
  );
endmodule
`default_nettype wire

[rtl/pre_front.sv]
`default_nettype none
module pre_front (
  input  wire logic          clk,
  input  wire logic          rst,
  pre_point_if.sink          points,
  input  wire logic          full,
  output logic               push,
  output pre_pkg::qent_t     entry
);
  import pre_pkg::*;

  logic [COORD_W-1:0] prev_x;
  logic [COORD_W-1:0] prev_y;
  logic [COORD_W-1:0] prev_z;
  logic               have_prev;

  assign points.ready = !full;
  assign push         = points.valid && !full;

  // A point with no stored predecessor starts a line, as if marked first.
  always_comb begin
    entry.first = points.first_point || !have_prev;
    entry.px    = points.point_x;
    entry.py    = points.point_y;
    entry.pz    = points.point_z;
    entry.qx    = prev_x;
    entry.qy    = prev_y;
    entry.qz    = prev_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      prev_x    <= '0;
      prev_y    <= '0;
      prev_z    <= '0;
    end else if (push) begin
      have_prev <= 1'b1;
      prev_x    <= points.point_x;
      prev_y    <= points.point_y;
      prev_z    <= points.point_z;
    end
  end
endmodule
`default_nettype wire

[rtl/pre_fifo.sv]
`default_nettype none
module pre_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire pre_pkg::qent_t wr_entry,
  input  wire logic           pop,
  output pre_pkg::qent_t      rd_entry,
  output logic                full,
  output logic                empty
);
  import pre_pkg::*;

  qent_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = count == 2'd2;
  assign empty    = count == 2'd0;
  assign rd_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

[rtl/pre_back.sv]
`default_nettype none
module pre_back (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    empty,
  input  wire pre_pkg::qent_t          head,
  output logic                         pop,
  input  wire logic [pre_pkg::MIN_W-1:0] min_len,
  pre_vertex_if.source                 verts
);
  import pre_pkg::*;

  back_state_t          state;
  back_state_t          state_next;
  qent_t                ent;
  logic [MAG_W-1:0]     mag [AXES];
  logic                 neg [AXES];
  logic [PROD_W-1:0]    prod;
  logic [SUM_W-1:0]     acc;
  logic [SUM_W-1:0]     rad;
  logic [ROOT_W-1:0]    root;
  logic [REM_W-1:0]     rem;
  logic [5:0]           cnt;
  logic [DREM_W-1:0]    drem [AXES];
  logic [QUOT_W-1:0]    nlow [AXES];
  logic [QUOT_W-1:0]    quot [AXES];
  logic [DIR_W-1:0]     dir  [AXES];
  logic [ARC_W-1:0]     running_arc;
  logic [ARC_W-1:0]     arc1;
  logic [2:0]           k;
  logic                 load;
  logic                 skip;
  logic [MAG_W-1:0]     sq_in;
  logic [REM_W-1:0]     r2;
  logic [REM_W-1:0]     trial;
  logic [ARC_W:0]       arc_sum;
  logic [1:0]           corner;
  logic                 at_new;

  always_comb begin
    unique case (cnt[1:0])
      2'd0:    sq_in = mag[0];
      2'd1:    sq_in = mag[1];
      default: sq_in = mag[2];
    endcase
  end

  assign r2      = {rem[REM_W-3:0], rad[SUM_W-1 -: 2]};
  assign trial   = {1'b0, root, 2'b01};
  assign skip    = (root == '0) || (root < {{(ROOT_W-MIN_W){1'b0}}, min_len});
  assign arc_sum = {1'b0, running_arc} + {{(ARC_W+1-ROOT_W){1'b0}}, root};

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      dir[i] = neg[i] ? DIR_W'(-{1'b0, quot[i]}) : {1'b0, quot[i]};
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (!empty && !head.first) state_next = ST_SQUARE;
      ST_SQUARE: if (cnt == SQ_LAST) state_next = ST_ROOT;
      ST_ROOT:   if (cnt == '0) state_next = ST_CHECK;
      ST_CHECK:  state_next = skip ? ST_IDLE : ST_DIVIDE;
      ST_DIVIDE: if (cnt == '0) state_next = ST_EMIT;
      ST_EMIT:   if (load && k == VTX_LAST) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop  = (state == ST_IDLE) && !empty;
    load = (state == ST_EMIT) && (!verts.valid || verts.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_arc <= '0;
      verts.valid <= 1'b0;
      cnt         <= '0;
      k           <= '0;
    end else begin
      if (verts.valid && verts.ready && !load) begin
        verts.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            ent <= head;
            acc <= '0;
            cnt <= '0;
            if (head.first) begin
              running_arc <= '0;
            end
            begin
              logic signed [MAG_W-1:0] d [AXES];
              d[0] = $signed({head.px[31], head.px}) - $signed({head.qx[31], head.qx});
              d[1] = $signed({head.py[31], head.py}) - $signed({head.qy[31], head.qy});
              d[2] = $signed({head.pz[31], head.pz}) - $signed({head.qz[31], head.qz});
              for (int i = 0; i < AXES; i++) begin
                neg[i] <= d[i][MAG_W-1];
                mag[i] <= d[i][MAG_W-1] ? MAG_W'(-d[i]) : MAG_W'(d[i]);
              end
            end
          end
        end
        ST_SQUARE: begin
          prod <= sq_in * sq_in;
          if (cnt != '0) begin
            acc <= acc + {2'b00, prod};
          end
          if (cnt == SQ_LAST) begin
            rad  <= acc + {2'b00, prod};
            root <= '0;
            rem  <= '0;
            cnt  <= ROOT_FIRST;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        ST_ROOT: begin
          // One result bit per cycle, two radicand bits brought down each time.
          if (r2 >= trial) begin
            rem  <= r2 - trial;
            root <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            rem  <= r2;
            root <= {root[ROOT_W-2:0], 1'b0};
          end
          rad <= {rad[SUM_W-3:0], 2'b00};
          cnt <= cnt - 6'd1;
        end
        ST_CHECK: begin
          arc1 <= arc_sum[ARC_W] ? ARC_MAX : arc_sum[ARC_W-1:0];
          cnt  <= DIV_FIRST;
          for (int i = 0; i < AXES; i++) begin
            logic [NUM_W-1:0] n;
            n = {mag[i], 14'd0} + {{(NUM_W-ROOT_W+1){1'b0}}, root[ROOT_W-1:1]};
            drem[i] <= {{(DREM_W-(NUM_W-QUOT_W)){1'b0}}, n[NUM_W-1:QUOT_W]};
            nlow[i] <= n[QUOT_W-1:0];
            quot[i] <= '0;
          end
        end
        ST_DIVIDE: begin
          for (int i = 0; i < AXES; i++) begin
            logic [DREM_W:0] t;
            t = {drem[i], nlow[i][QUOT_W-1]};
            if (t >= {1'b0, root}) begin
              drem[i] <= DREM_W'(t - {1'b0, root});
              quot[i] <= {quot[i][QUOT_W-2:0], 1'b1};
            end else begin
              drem[i] <= t[DREM_W-1:0];
              quot[i] <= {quot[i][QUOT_W-2:0], 1'b0};
            end
            nlow[i] <= {nlow[i][QUOT_W-2:0], 1'b0};
          end
          cnt <= cnt - 6'd1;
          k   <= '0;
        end
        ST_EMIT: begin
          if (load) begin
            verts.valid <= 1'b1;
            k           <= k + 3'd1;
            if (k == VTX_LAST) begin
              running_arc <= arc1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign corner = corner_of(k);
  assign at_new = corner[1];

  always_ff @(posedge clk) begin
    if (load) begin
      verts.vert_x      <= at_new ? ent.px : ent.qx;
      verts.vert_y      <= at_new ? ent.py : ent.qy;
      verts.vert_z      <= at_new ? ent.pz : ent.qz;
      verts.dir_x       <= dir[0];
      verts.dir_y       <= dir[1];
      verts.dir_z       <= dir[2];
      verts.arc_length  <= at_new ? arc1 : running_arc;
      verts.side        <= corner[0];
      verts.last_vertex <= k == VTX_LAST;
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIVIDE |-> root != '0)
    else $error("divide entered with zero length");
  a_last_side: assert property (@(posedge clk) disable iff (rst)
    verts.valid && verts.last_vertex |-> !verts.side)
    else $error("last vertex not on the negative side");
  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> k <= VTX_LAST)
    else $error("vertex counter overrun");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    pop |-> state == ST_IDLE && !empty)
    else $error("queue popped while busy");
endmodule
`default_nettype wire
